// ----- hw/rtl/cdq_pkg.sv -----
// Shared types and constants for the circular deque.
`timescale 1ns / 1ps
package cdq_pkg;

	localparam int DATA_W  = 32;
	localparam int CAP_W   = 5;
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;

	localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
	localparam logic [PADDR_W-1:0] CAP_ADDR  = 2'd0;

	typedef enum logic [1:0] {
		ACT_PUSH_REAR  = 2'd0,
		ACT_PUSH_FRONT = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_REAR   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		action_t                   action;
		logic signed [DATA_W-1:0]  push_value;
	} item_t;

	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  popped_value;
		logic [CAP_W-1:0]          occupancy;
	} result_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_EXEC,
		CS_WB
	} ctl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic item_load;
		logic exec;
		logic out_load;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

// ----- hw/rtl/circular_deque.sv -----
// Top level of the circular deque: controller, datapath and configuration port.
`timescale 1ns / 1ps
// Double-ended queue in a circular buffer of DEPTH entries, of which the
// first "capacity" are used (register 0 at byte address 0; 0 acts as 1,
// values above DEPTH act as DEPTH; any write empties the queue). Each input
// transaction pushes at the rear or front or pops at the front or rear and
// gives exactly one result transaction: status, popped value (zero unless a
// pop succeeded) and occupancy after the operation. A rejected push or pop
// leaves the queue untouched. One operation is in flight at a time and passes
// three steps from acceptance to the result register: accept, execute (one
// entry memory write or registered read plus the index update), and
// writeback into the output register. The next transaction is accepted as
// soon as the writeback is done, even while the previous result is still
// stalled downstream; writeback waits only when the output register still
// holds an untaken result. Entries need no clearing after reset; only
// entries written by a push are ever returned. Configure only while idle.
module circular_deque
	import cdq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// operation transactions
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	// result transactions
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	ctl_cmd_t         cmd;
	dp_sts_t          sts;
	logic             cfg_we;
	logic [CAP_W-1:0] cap_value;

	// capacity is the only register, so every completed write lands on it
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = (paddr == CAP_ADDR) ? {{(PDATA_W-CAP_W){1'b0}}, cap_value} : '0;

	cdq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	cdq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_cap      (pwdata[CAP_W-1:0]),
		.cap_value    (cap_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// one operation at a time: after a transaction is taken, input stalls
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("input accepted again while an operation is in flight");

	// writeback never overwrites an untaken result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register loaded while still held");

	// a rejected push returns no data
	a_full_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == ST_FULL) |-> (result.popped_value == '0))
		else $error("rejected push carries popped data");

	// a rejected pop means the queue held nothing
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == ST_EMPTY) |-> (result.occupancy == '0))
		else $error("rejected pop with nonzero occupancy");

endmodule

// ----- hw/rtl/cdq_ctrl.sv -----
// Sequencing state machine for the circular deque.
`timescale 1ns / 1ps
module cdq_ctrl
	import cdq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd.item_load = 1'b0;
		cmd.exec      = 1'b0;
		cmd.out_load  = 1'b0;
		item_stall    = 1'b1;
		case (state_q)
			CS_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.item_load = 1'b1;
					state_d       = CS_EXEC;
				end
			end
			CS_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = CS_WB;
			end
			CS_WB: begin
				// wait for a free output register
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/cdq_dp.sv -----
// Datapath of the circular deque: entry memory, indices, capacity and output register.
`timescale 1ns / 1ps
module cdq_dp
	import cdq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            item,
	input  ctl_cmd_t         cmd,
	output dp_sts_t          sts,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_cap,
	output logic [CAP_W-1:0] cap_value,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [CAP_W-1:0] DEPTH_CAP =
		(DEPTH < (2 ** CAP_W - 1)) ? CAP_W'(DEPTH) : CAP_W'(2 ** CAP_W - 1);

	logic [DATA_W-1:0] mem [DEPTH];

	logic [CAP_W-1:0]         cap_q;
	logic [CAP_W-1:0]         head_q;
	logic [CAP_W-1:0]         tail_q;
	logic                     empty_q;
	action_t                  act_q;
	logic signed [DATA_W-1:0] val_q;
	logic [DATA_W-1:0]        rd_q;
	status_t                  status_q;
	logic                     pop_ok_q;
	logic                     out_valid_q;
	result_t                  out_q;

	logic [CAP_W-1:0] cap_u;
	logic [CAP_W:0]   held_sum;
	logic [CAP_W-1:0] held_now;
	logic             full;
	logic [CAP_W-1:0] tail_inc;
	logic [CAP_W-1:0] tail_dec;
	logic [CAP_W-1:0] head_inc;
	logic [CAP_W-1:0] head_dec;
	logic [CAP_W-1:0] head_d;
	logic [CAP_W-1:0] tail_d;
	logic             empty_d;
	logic             we;
	logic [CAP_W-1:0] widx;
	logic [CAP_W-1:0] ridx;
	status_t          st;
	logic             pop_ok;
	logic [AW+CAP_W-1:0] wext;
	logic [AW+CAP_W-1:0] rext;
	logic [AW-1:0]       waddr;
	logic [AW-1:0]       raddr;

	// usable capacity: zero acts as one, above the built depth acts as the depth
	always_comb begin
		cap_u = cap_q;
		if (cap_q == '0) begin
			cap_u = CAP_W'(1);
		end else if (cap_q > DEPTH_CAP) begin
			cap_u = DEPTH_CAP;
		end
	end

	// entries held, from the current indices
	always_comb begin
		if (tail_q >= head_q) begin
			held_sum = {1'b0, tail_q} - {1'b0, head_q} + (CAP_W+1)'(1);
		end else begin
			held_sum = {1'b0, tail_q} + {1'b0, cap_u} - {1'b0, head_q} + (CAP_W+1)'(1);
		end
		held_now = empty_q ? '0 : held_sum[CAP_W-1:0];
		full     = (held_now >= cap_u);
	end

	assign tail_inc = (({1'b0, tail_q} + (CAP_W+1)'(1)) >= {1'b0, cap_u}) ? '0
		: tail_q + CAP_W'(1);
	assign head_inc = (({1'b0, head_q} + (CAP_W+1)'(1)) >= {1'b0, cap_u}) ? '0
		: head_q + CAP_W'(1);
	assign tail_dec = (tail_q == '0) ? cap_u - CAP_W'(1) : tail_q - CAP_W'(1);
	assign head_dec = (head_q == '0) ? cap_u - CAP_W'(1) : head_q - CAP_W'(1);

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		empty_d = empty_q;
		we      = 1'b0;
		widx    = '0;
		st      = ST_DONE;
		pop_ok  = 1'b0;
		if (act_q inside {ACT_PUSH_REAR, ACT_PUSH_FRONT}) begin
			if (full) begin
				st = ST_FULL;
			end else if (empty_q) begin
				head_d  = '0;
				tail_d  = '0;
				empty_d = 1'b0;
				we      = 1'b1;
			end else if (act_q == ACT_PUSH_REAR) begin
				tail_d = tail_inc;
				we     = 1'b1;
				widx   = tail_inc;
			end else begin
				head_d = head_dec;
				we     = 1'b1;
				widx   = head_dec;
			end
		end else begin
			if (empty_q) begin
				st = ST_EMPTY;
			end else begin
				pop_ok = 1'b1;
				if (head_q == tail_q) begin
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b1;
				end else if (act_q == ACT_POP_FRONT) begin
					head_d = head_inc;
				end else begin
					tail_d = tail_dec;
				end
			end
		end
	end

	assign ridx  = (act_q == ACT_POP_FRONT) ? head_q : tail_q;
	assign wext  = {{AW{1'b0}}, widx};
	assign rext  = {{AW{1'b0}}, ridx};
	assign waddr = wext[AW-1:0];
	assign raddr = rext[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (cfg_we) begin
			cap_q   <= cfg_cap;
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			empty_q <= empty_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			act_q <= item.action;
			val_q <= item.push_value;
		end
		if (cmd.exec) begin
			status_q <= st;
			pop_ok_q <= pop_ok;
		end
	end

	// entry memory: at most one write and one registered read per cycle, both only while executing
	always_ff @(posedge clk) begin
		if (cmd.exec && we) begin
			mem[waddr] <= val_q;
		end
		if (cmd.exec) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.status       <= status_q;
			out_q.popped_value <= pop_ok_q ? rd_q : '0;
			out_q.occupancy    <= held_now;
		end
	end

	assign sts.out_free = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign cap_value    = cap_q;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for circular_deque: queue operations, capacity register, back-pressure.
`timescale 1ns / 1ps
module tb_top
	import cdq_pkg::*;
();

	localparam int DEPTH     = 16;
	localparam int CLK_HALF  = 4;
	localparam int DRAIN_CYC = 4;     // covers the accept, execute and writeback steps

	// ------------------------------------------------------------------
	// DUT signals; every input starts from a known value
	// ------------------------------------------------------------------
	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               item_stall;
	item_t              item         = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_t            result;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [PADDR_W-1:0] paddr        = '0;
	logic [PDATA_W-1:0] pwdata       = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	circular_deque #(.DEPTH(DEPTH)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// ------------------------------------------------------------------
	// Shadow deque: our own copy of the buffer, indices and capacity reg
	// ------------------------------------------------------------------
	logic [DATA_W-1:0] shadow_store [DEPTH];
	int                shadow_head;
	int                shadow_tail;
	bit                shadow_empty;
	logic [CAP_W-1:0]  shadow_cap;

	result_t expected_results [$];

	int  err_count   = 0;
	int  n_sent      = 0;
	int  n_checked   = 0;
	int  n_full      = 0;
	int  n_empty     = 0;
	int  n_cfg       = 0;
	bit  no_idle     = 1'b0;   // set for stretches with no gaps on either side
	int  hold_req    = 0;      // receiver hold-off request, in cycles

	// Register value 0 behaves as 1, anything above DEPTH behaves as DEPTH.
	function automatic int eff_cap();
		if (shadow_cap == 0)
			return 1;
		if (shadow_cap > DEPTH)
			return DEPTH;
		return shadow_cap;
	endfunction

	function automatic int shadow_held(int cap);
		if (shadow_empty)
			return 0;
		return ((shadow_tail + cap - shadow_head) % cap) + 1;
	endfunction

	function automatic void shadow_clear();
		shadow_head  = 0;
		shadow_tail  = 0;
		shadow_empty = 1'b1;
	endfunction

	// Applies one operation to the shadow deque and returns what the block must report.
	function automatic result_t deque_apply(action_t act, logic [DATA_W-1:0] val);
		int      cap;
		result_t r;
		cap            = eff_cap();
		r.status       = ST_DONE;
		r.popped_value = '0;
		if (act == ACT_PUSH_REAR || act == ACT_PUSH_FRONT) begin
			if (shadow_held(cap) >= cap) begin
				r.status = ST_FULL;
			end else if (shadow_empty) begin
				// first entry always lands in slot 0, whichever end
				shadow_head     = 0;
				shadow_tail     = 0;
				shadow_empty    = 1'b0;
				shadow_store[0] = val;
			end else if (act == ACT_PUSH_REAR) begin
				shadow_tail = (shadow_tail + 1 >= cap) ? 0 : shadow_tail + 1;
				shadow_store[shadow_tail] = val;
			end else begin
				shadow_head = (shadow_head == 0) ? cap - 1 : shadow_head - 1;
				shadow_store[shadow_head] = val;
			end
		end else if (shadow_empty) begin
			r.status = ST_EMPTY;
		end else if (act == ACT_POP_FRONT) begin
			r.popped_value = shadow_store[shadow_head];
			if (shadow_head == shadow_tail)
				shadow_clear();
			else
				shadow_head = (shadow_head + 1 >= cap) ? 0 : shadow_head + 1;
		end else begin
			r.popped_value = shadow_store[shadow_tail];
			if (shadow_head == shadow_tail)
				shadow_clear();
			else
				shadow_tail = (shadow_tail == 0) ? cap - 1 : shadow_tail - 1;
		end
		r.occupancy = CAP_W'(shadow_held(cap));
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Mostly back-to-back, some short gaps, rarely a long one.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Random word, with the signed extremes and zero mixed in.
	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 15))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// fill biases toward pushes, otherwise toward pops; some pure noise
	function automatic action_t pick_action(bit fill);
		int pct;
		bit side;
		pct  = fill ? 80 : 20;
		if ($urandom_range(0, 9) == 0)
			pct = 50;
		side = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < pct)
			return side ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
		return side ? ACT_POP_REAR : ACT_POP_FRONT;
	endfunction

	// ------------------------------------------------------------------
	// Sender: one transaction per call. valid stays high across back-to-back
	// calls; the prediction is taken at the accepting edge.
	// ------------------------------------------------------------------
	task automatic send_op(input action_t act, input logic [DATA_W-1:0] val);
		int      gap;
		result_t r;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{action: act, push_value: val};
		do
			@(posedge clk);
		while (item_stall);
		r = deque_apply(act, val);
		if (r.status == ST_FULL)
			n_full++;
		if (r.status == ST_EMPTY)
			n_empty++;
		expected_results.push_back(r);
		n_sent++;
	endtask

	// Drop valid and wait until the block has nothing left in flight.
	task automatic drain_results();
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic cfg_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write capacity (junk in the unused upper bits), track it, read it back.
	// Any write also empties the queue.
	task automatic program_capacity(input logic [CAP_W-1:0] cap);
		logic [PDATA_W-1:0] data;
		logic [PDATA_W-1:0] rd;
		data            = $urandom;
		data[CAP_W-1:0] = cap;
		cfg_write(CAP_ADDR, data);
		shadow_cap = cap;
		shadow_clear();
		n_cfg++;
		cfg_read(CAP_ADDR, rd);
		if (rd[CAP_W-1:0] !== cap) begin
			$error("capacity: expected %0d, got %0d", cap, rd[CAP_W-1:0]);
			err_count++;
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus a counted hold-off on request
	// ------------------------------------------------------------------
	initial begin : receiver
		int n;
		forever begin
			@(posedge clk);
			n = pick_gap();
			if (hold_req > 0) begin
				n        = hold_req;
				hold_req = 0;
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end else if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every accepted transaction against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d popped %0d occupancy %0d",
					result.status, result.popped_value, result.occupancy);
				err_count++;
			end else begin
				e = expected_results[0];
				expected_results.delete(0);
				n_checked++;
				if (result.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, result.status);
					err_count++;
				end
				if (result.popped_value !== e.popped_value) begin
					$error("popped_value: expected %0d, got %0d",
						e.popped_value, result.popped_value);
					err_count++;
				end
				if (result.occupancy !== e.occupancy) begin
					$error("occupancy: expected %0d, got %0d", e.occupancy, result.occupancy);
					err_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Register must come out of reset at full depth.
	task automatic test_reset_value();
		logic [PDATA_W-1:0] rd;
		cfg_read(CAP_ADDR, rd);
		if (rd[CAP_W-1:0] !== CAP_RESET) begin
			$error("capacity: expected %0d, got %0d", CAP_RESET, rd[CAP_W-1:0]);
			err_count++;
		end
	endtask

	// Empty pops, value extremes, pop of the last entry, capacity 0 acting as 1,
	// full rejects on both ends.
	task automatic test_directed();
		send_op(ACT_POP_FRONT, 32'h1234_5678);
		send_op(ACT_POP_REAR, 32'hFFFF_FFFF);
		send_op(ACT_PUSH_REAR, 32'h7FFF_FFFF);
		send_op(ACT_PUSH_FRONT, 32'h8000_0000);   // wraps head to cap-1
		send_op(ACT_PUSH_REAR, 32'hFFFF_FFFF);
		send_op(ACT_PUSH_FRONT, 32'h0000_0000);
		send_op(ACT_POP_FRONT, 32'h0);
		send_op(ACT_POP_REAR, 32'h0);
		send_op(ACT_POP_FRONT, 32'h0);
		send_op(ACT_POP_REAR, 32'h0);             // last one, back to empty
		send_op(ACT_POP_FRONT, 32'h0);
		drain_results();

		program_capacity(5'd0);                   // behaves as one entry
		send_op(ACT_PUSH_FRONT, 32'h5555_AAAA);
		send_op(ACT_PUSH_REAR, 32'h1111_1111);
		send_op(ACT_PUSH_FRONT, 32'h2222_2222);
		send_op(ACT_POP_REAR, 32'h0);
		send_op(ACT_POP_FRONT, 32'h0);
		drain_results();

		program_capacity(5'd2);
		send_op(ACT_PUSH_REAR, 32'hAAAA_5555);
		send_op(ACT_PUSH_FRONT, 32'hDEAD_BEEF);
		send_op(ACT_PUSH_REAR, 32'h0BAD_F00D);
		send_op(ACT_POP_REAR, 32'h0);
		send_op(ACT_POP_REAR, 32'h0);
		send_op(ACT_POP_FRONT, 32'h0);
		drain_results();
	endtask

	// Fill/drain bursts with random content over a sweep of capacity settings,
	// out-of-range values included.
	task automatic test_random_mix();
		logic [CAP_W-1:0] plan [0:13];
		int               run;
		bit               fill;
		plan = '{5'd16, 5'd1, 5'd2, 5'd3, 5'd31, 5'd5, 5'd0,
			5'd8, 5'd17, 5'd4, 5'd16, 5'd7, 5'd12, 5'd9};
		for (int p = 0; p < 14; p++) begin
			drain_results();
			program_capacity(plan[p]);
			no_idle = (p % 4 == 3);
			fill    = 1'b0;
			run     = 0;
			for (int k = 0; k < 110; k++) begin
				if (run == 0) begin
					fill = ~fill;
					run  = $urandom_range(1, 2 * eff_cap() + 2);
				end
				run--;
				send_op(pick_action(fill), rand_word());
			end
		end
		drain_results();
		no_idle = 1'b0;
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering.
	task automatic test_backpressure();
		program_capacity(5'd16);
		@(negedge clk);
		hold_req = 150;
		@(posedge clk);
		no_idle = 1'b1;
		for (int k = 0; k < 40; k++)
			send_op(pick_action(k < 24), rand_word());
		no_idle = 1'b0;
		drain_results();
	endtask

	// Sender goes quiet mid-stream until everything is back, no reconfig.
	task automatic test_sender_pause();
		for (int k = 0; k < 30; k++)
			send_op(pick_action(1'b1), rand_word());
		drain_results();
		for (int k = 0; k < 30; k++)
			send_op(pick_action(1'b0), rand_word());
		drain_results();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		shadow_cap = CAP_RESET;
		shadow_clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_value();
		test_directed();
		test_backpressure();
		test_sender_pause();
		test_random_mix();

		drain_results();
		repeat (10) @(posedge clk);

		$display("Ran %0d transactions, checked %0d results over %0d capacity writes",
			n_sent, n_checked, n_cfg);
		$display("Rejected pushes on full: %0d, rejected pops on empty: %0d", n_full, n_empty);
		if (err_count == 0) begin
			$display("** circular_deque: PASSED **");
		end else begin
			$display("** circular_deque: FAILED **");
		end
		$finish;
	end

	// Watchdog, well above the slowest legal run.
	initial begin
		#10_000_000;
		$display("Timeout with %0d results outstanding", expected_results.size());
		$display("** circular_deque: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_ctrl.sv
hw/rtl/cdq_dp.sv
hw/rtl/circular_deque.sv
sim/tb_top.sv
